/* rtl/sacl_pkg.sv */
// ----------------------------------------------------------------------------
// sacl_pkg
// shared types and codes of the set-associative tag lookup
// ----------------------------------------------------------------------------
package sacl_pkg;

    localparam int DEF_SETS  = 256;
    localparam int DEF_WAYS  = 8;
    localparam int ADDR_BITS = 48;
    localparam int CNT_BITS  = 32;

    // register indexes
    localparam logic [1:0] REG_POLICY     = 2'd0;
    localparam logic [1:0] REG_OFFSET     = 2'd1;
    localparam logic [1:0] REG_SET_INDEX  = 2'd2;
    localparam logic [1:0] REG_WAYS_LOG2  = 2'd3;

    // replacement policy codes, the spare code behaves as lru
    localparam logic [1:0] POL_LRU    = 2'd0;
    localparam logic [1:0] POL_RANDOM = 2'd1;
    localparam logic [1:0] POL_FIFO   = 2'd2;

    localparam logic [15:0] LFSR_SEED = 16'hACE1;

    typedef struct packed {
        logic                 operation;
        logic [ADDR_BITS-1:0] address;
    } in_word_t;

    typedef struct packed {
        logic                hit;
        logic [2:0]          way;
        logic [CNT_BITS-1:0] reads_seen;
        logic [CNT_BITS-1:0] read_misses;
        logic [CNT_BITS-1:0] writes_seen;
        logic [CNT_BITS-1:0] write_misses;
    } out_word_t;

    typedef struct packed {
        logic [1:0] policy;
        logic [3:0] offset_bits;
        logic [3:0] set_index_bits;
        logic [1:0] ways_log2;
    } cfg_t;

    typedef struct packed {
        logic clearing;
        logic look;
    } bk_stat_t;

    typedef enum logic [1:0] {
        BK_CLEAR,
        BK_IDLE,
        BK_LOOK
    } bk_state_t;

endpackage

/* rtl/set_assoc_cache_tag_lookup.sv */
// ----------------------------------------------------------------------------
// set_assoc_cache_tag_lookup
// tag store of a set-associative cache with lru, random and fifo replacement
// ----------------------------------------------------------------------------
// flow: a word passes the command queue, the set row read and write back, then the result
//   queue; the back takes the next word only after the write back, with room for a result
// reset: all control state cleared, then a clearing pass over all SETS rows zeroes the
//   tag store; full stays high during the pass, configuration writes are taken
// ----------------------------------------------------------------------------
module set_assoc_cache_tag_lookup
    import sacl_pkg::*;
#(
    parameter int SETS = DEF_SETS,
    parameter int WAYS = DEF_WAYS
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       push,
    output logic       full,
    input  in_word_t   in_word,
    output logic       empty,
    input  logic       pop,
    output out_word_t  result,
    input  logic       wr_en,
    input  logic [1:0] wr_index,
    input  logic [3:0] wr_data
);

    localparam int SW = (SETS > 1) ? $clog2(SETS) : 1;
    localparam int IW = 1 + SW + ADDR_BITS;

    // configuration registers
    cfg_t cfg_reg;

    // front to back queue
    logic                 f_op;
    logic [SW-1:0]        f_set;
    logic [ADDR_BITS-1:0] f_tag;
    logic [IW-1:0]        q_dout;
    logic                 q_full, q_empty, q_pop;

    // back to result queue
    logic      res_push, res_full;
    out_word_t res_word;
    bk_stat_t  bk_stat;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.policy         <= POL_LRU;
            cfg_reg.offset_bits    <= 4'd6;
            cfg_reg.set_index_bits <= 4'd8;
            cfg_reg.ways_log2      <= 2'd1;
        end
        else if (wr_en)
        begin
            unique case (wr_index)
                REG_POLICY:    cfg_reg.policy         <= wr_data[1:0];
                REG_OFFSET:    cfg_reg.offset_bits    <= wr_data;
                REG_SET_INDEX: cfg_reg.set_index_bits <= wr_data;
                REG_WAYS_LOG2: cfg_reg.ways_log2      <= wr_data[1:0];
                default:       cfg_reg.policy         <= cfg_reg.policy;
            endcase
        end
    end

    // front: split address into set and tag
    sacl_front #(.SETS(SETS)) u_front (
        .in_word (in_word),
        .cfg     (cfg_reg),
        .op      (f_op),
        .set_idx (f_set),
        .tag     (f_tag)
    );

    // no word is taken while the store is being cleared
    assign full = q_full || bk_stat.clearing;

    sacl_fifo #(.WIDTH(IW), .DEPTH(2)) u_cmd_q (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (push && !bk_stat.clearing),
        .din   ({f_op, f_set, f_tag}),
        .full  (q_full),
        .pop   (q_pop),
        .dout  (q_dout),
        .empty (q_empty)
    );

    // back: read the set, compare, pick a victim, write the row back
    sacl_back #(.SETS(SETS), .WAYS(WAYS)) u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg_reg),
        .item       (q_dout),
        .item_empty (q_empty),
        .item_pop   (q_pop),
        .res_full   (res_full),
        .res_push   (res_push),
        .res_word   (res_word),
        .stat       (bk_stat)
    );

    // result queue decouples the back from the consumer
    sacl_fifo #(.WIDTH($bits(out_word_t)), .DEPTH(2)) u_res_q (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (res_push),
        .din   (res_word),
        .full  (res_full),
        .pop   (pop),
        .dout  (result),
        .empty (empty)
    );

    // the clearing pass blocks the input side
    a_clear_blocks: assert property (@(posedge clk) disable iff (!rst_n)
        bk_stat.clearing |-> full)
        else $error("word could be taken during clearing pass");

    // a result is only produced with room in the result queue
    a_res_room: assert property (@(posedge clk) disable iff (!rst_n)
        res_push |-> !res_full)
        else $error("result pushed into full queue");

    // a look-up with its write back is never directly followed by another look-up
    a_two_cycle: assert property (@(posedge clk) disable iff (!rst_n)
        bk_stat.look |=> !bk_stat.look)
        else $error("back started a look-up before write back");

endmodule

/* rtl/sacl_ram.sv */
// ----------------------------------------------------------------------------
// sacl_ram
// generic single write, single read ram with registered read data
// ----------------------------------------------------------------------------
module sacl_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

/* rtl/sacl_fifo.sv */
// ----------------------------------------------------------------------------
// sacl_fifo
// short register queue between front and back, and on the result side
// ----------------------------------------------------------------------------
module sacl_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2,
    localparam int PW   = (DEPTH > 1) ? $clog2(DEPTH) : 1,
    localparam int CW   = $clog2(DEPTH + 1)
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  logic [WIDTH-1:0] din,
    output logic             full,
    input  logic             pop,
    output logic [WIDTH-1:0] dout,
    output logic             empty
);

    logic [WIDTH-1:0] data_reg [DEPTH];
    logic [PW-1:0]    wptr_reg, wptr_next;
    logic [PW-1:0]    rptr_reg, rptr_next;
    logic [CW-1:0]    cnt_reg, cnt_next;
    logic             do_push, do_pop;

    assign full    = (cnt_reg == CW'(DEPTH));
    assign empty   = (cnt_reg == '0);
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign dout    = data_reg[rptr_reg];

    always_comb
    begin
        wptr_next = wptr_reg;
        rptr_next = rptr_reg;
        cnt_next  = cnt_reg;
        if (do_push)
        begin
            wptr_next = (wptr_reg == PW'(DEPTH - 1)) ? '0 : wptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rptr_next = (rptr_reg == PW'(DEPTH - 1)) ? '0 : rptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            cnt_next = cnt_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg <= '0;
            rptr_reg <= '0;
            cnt_reg  <= '0;
        end
        else
        begin
            wptr_reg <= wptr_next;
            rptr_reg <= rptr_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            data_reg[wptr_reg] <= din;
        end
    end

endmodule

/* rtl/sacl_front.sv */
// ----------------------------------------------------------------------------
// sacl_front
// splits an incoming address into set index and tag
// ----------------------------------------------------------------------------
module sacl_front
    import sacl_pkg::*;
#(
    parameter int SETS  = DEF_SETS,
    localparam int SW   = (SETS > 1) ? $clog2(SETS) : 1,
    localparam int SLOG = $clog2(SETS + 1) - 1
) (
    input  in_word_t             in_word,
    input  cfg_t                 cfg,
    output logic                 op,
    output logic [SW-1:0]        set_idx,
    output logic [ADDR_BITS-1:0] tag
);

    logic [3:0]           sbits;
    logic [SW-1:0]        set_mask;
    logic [ADDR_BITS-1:0] shifted;
    logic [4:0]           tag_pos;

    // set count above the store aliases onto the largest fitting index
    assign sbits     = (cfg.set_index_bits > 4'(SLOG)) ? 4'(SLOG) : cfg.set_index_bits;
    assign set_mask  = ~(~SW'(0) << sbits);
    assign shifted   = in_word.address >> cfg.offset_bits;
    assign set_idx   = shifted[SW-1:0] & set_mask;
    assign tag_pos   = {1'b0, cfg.offset_bits} + {1'b0, cfg.set_index_bits};
    assign tag       = in_word.address >> tag_pos;
    assign op        = in_word.operation;

endmodule

/* rtl/sacl_back.sv */
// ----------------------------------------------------------------------------
// sacl_back
// set read, tag compare, victim choice and write-back of one access
// ----------------------------------------------------------------------------
module sacl_back
    import sacl_pkg::*;
#(
    parameter int SETS  = DEF_SETS,
    parameter int WAYS  = DEF_WAYS,
    localparam int SW   = (SETS > 1) ? $clog2(SETS) : 1,
    localparam int WW   = (WAYS > 1) ? $clog2(WAYS) : 1,
    localparam int WLOG = $clog2(WAYS + 1) - 1,
    localparam int IW   = 1 + SW + ADDR_BITS
) (
    input  logic             clk,
    input  logic             rst_n,
    input  cfg_t             cfg,
    input  logic [IW-1:0]    item,
    input  logic             item_empty,
    output logic             item_pop,
    input  logic             res_full,
    output logic             res_push,
    output out_word_t        res_word,
    output bk_stat_t         stat
);

    localparam int TAG_LO = WAYS;
    localparam int STP_LO = TAG_LO + WAYS * ADDR_BITS;
    localparam int PTR_LO = STP_LO + WAYS * CNT_BITS;
    localparam int RW     = PTR_LO + WW;

    bk_state_t state_reg, state_next;
    logic [SW-1:0]         clr_reg, clr_next;
    logic [IW-1:0]         item_reg;
    logic [CNT_BITS-1:0]   acc_reg, acc_next;
    logic [15:0]           lfsr_reg, lfsr_next;
    logic [CNT_BITS-1:0]   stat_reg [4];
    logic [CNT_BITS-1:0]   stat_next [4];

    logic                  ram_we;
    logic [SW-1:0]         ram_waddr, ram_raddr;
    logic [RW-1:0]         ram_wdata, ram_rdata;

    logic [WAYS-1:0]                 r_valid;
    logic [WAYS-1:0][ADDR_BITS-1:0]  r_tags;
    logic [WAYS-1:0][CNT_BITS-1:0]   r_stamps;
    logic [WW-1:0]                   r_ptr;

    logic                  it_op;
    logic [SW-1:0]         it_set;
    logic [ADDR_BITS-1:0]  it_tag;

    sacl_ram #(.WIDTH(RW), .DEPTH(SETS)) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign r_valid  = ram_rdata[WAYS-1:0];
    assign r_tags   = ram_rdata[TAG_LO +: WAYS * ADDR_BITS];
    assign r_stamps = ram_rdata[STP_LO +: WAYS * CNT_BITS];
    assign r_ptr    = ram_rdata[PTR_LO +: WW];

    assign {it_op, it_set, it_tag} = item_reg;
    assign ram_raddr = item[ADDR_BITS +: SW];

    always_comb
    begin
        logic [2:0]                     wl;
        logic [WW:0]                    nways;
        logic [WW-1:0]                  wmask;
        logic                           lru;
        logic                           hit;
        logic [WW-1:0]                  way;
        logic [CNT_BITS-1:0]            best;
        logic [WAYS-1:0]                w_valid;
        logic [WAYS-1:0][ADDR_BITS-1:0] w_tags;
        logic [WAYS-1:0][CNT_BITS-1:0]  w_stamps;
        logic [WW-1:0]                  w_ptr;

        state_next = state_reg;
        clr_next   = clr_reg;
        acc_next   = acc_reg;
        lfsr_next  = lfsr_reg;
        stat_next  = stat_reg;
        item_pop   = 1'b0;
        res_push   = 1'b0;
        ram_we     = 1'b0;
        ram_waddr  = it_set;
        ram_wdata  = '0;
        best       = r_stamps[0];

        wl = ({1'b0, cfg.ways_log2} > 3'(WLOG)) ? 3'(WLOG) : {1'b0, cfg.ways_log2};
        nways = (WW + 1)'(1) << wl;
        wmask = WW'(nways - 1'b1);
        lru   = (cfg.policy != POL_RANDOM) && (cfg.policy != POL_FIFO);

        // first valid matching way of those in use
        hit = 1'b0;
        way = '0;
        for (int i = WAYS - 1; i >= 0; i--)
        begin
            if ((WW + 1)'(i) < nways && r_valid[i] && r_tags[i] == it_tag)
            begin
                hit = 1'b1;
                way = WW'(i);
            end
        end

        w_valid  = r_valid;
        w_tags   = r_tags;
        w_stamps = r_stamps;
        w_ptr    = r_ptr;

        if (state_reg == BK_LOOK)
        begin
            acc_next = acc_reg + 1'b1;
        end

        if (!hit)
        begin
            if (lru)
            begin
                // oldest stamp, ties to the lowest way
                best = r_stamps[0];
                way  = '0;
                for (int i = 1; i < WAYS; i++)
                begin
                    if ((WW + 1)'(i) < nways && r_stamps[i] < best)
                    begin
                        best = r_stamps[i];
                        way  = WW'(i);
                    end
                end
            end
            else if (cfg.policy == POL_RANDOM)
            begin
                if (state_reg == BK_LOOK)
                begin
                    lfsr_next = {lfsr_reg[0] ^ lfsr_reg[2] ^ lfsr_reg[3] ^ lfsr_reg[5],
                                 lfsr_reg[15:1]};
                end
                way = WW'(lfsr_next) & wmask;
            end
            else
            begin
                way   = r_ptr & wmask;
                w_ptr = (way + 1'b1) & wmask;
            end
            w_valid[way] = 1'b1;
            w_tags[way]  = it_tag;
        end
        if (lru)
        begin
            w_stamps[way] = acc_next;
        end

        res_word.hit = hit;
        res_word.way = 3'(way);

        unique case (state_reg)
            BK_CLEAR:
            begin
                ram_we    = 1'b1;
                ram_waddr = clr_reg;
                ram_wdata = '0;
                clr_next  = clr_reg + 1'b1;
                if (clr_reg == SW'(SETS - 1))
                begin
                    state_next = BK_IDLE;
                end
            end
            BK_IDLE:
            begin
                if (!item_empty && !res_full)
                begin
                    item_pop   = 1'b1;
                    state_next = BK_LOOK;
                end
            end
            BK_LOOK:
            begin
                ram_we    = 1'b1;
                ram_wdata = {w_ptr, w_stamps, w_tags, w_valid};
                res_push  = 1'b1;
                if (!it_op)
                begin
                    if (stat_reg[0] != '1) stat_next[0] = stat_reg[0] + 1'b1;
                    if (!hit && stat_reg[1] != '1) stat_next[1] = stat_reg[1] + 1'b1;
                end
                else
                begin
                    if (stat_reg[2] != '1) stat_next[2] = stat_reg[2] + 1'b1;
                    if (!hit && stat_reg[3] != '1) stat_next[3] = stat_reg[3] + 1'b1;
                end
                state_next = BK_IDLE;
            end
            default:
            begin
                state_next = BK_IDLE;
            end
        endcase

        res_word.reads_seen   = stat_next[0];
        res_word.read_misses  = stat_next[1];
        res_word.writes_seen  = stat_next[2];
        res_word.write_misses = stat_next[3];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= BK_CLEAR;
            clr_reg   <= '0;
            acc_reg   <= '0;
            lfsr_reg  <= LFSR_SEED;
            for (int i = 0; i < 4; i++)
            begin
                stat_reg[i] <= '0;
            end
        end
        else
        begin
            state_reg <= state_next;
            clr_reg   <= clr_next;
            acc_reg   <= acc_next;
            lfsr_reg  <= lfsr_next;
            stat_reg  <= stat_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (item_pop)
        begin
            item_reg <= item;
        end
    end

    assign stat.clearing = (state_reg == BK_CLEAR);
    assign stat.look     = (state_reg == BK_LOOK);

endmodule
